// ===== src/wth_pkg.sv =====
// Shared types and constants for the word tokenizer and hasher.
package wth_pkg;

	localparam int unsigned TABLE_SIZE  = 10007;
	localparam int unsigned REM_W       = $clog2(TABLE_SIZE);
	localparam int unsigned RW          = REM_W + 1;
	localparam int unsigned RECIP_SHIFT = 31 + REM_W;
	localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / 64'(TABLE_SIZE));
	localparam logic [RW-1:0] TABLE_SIZE_R = RW'(TABLE_SIZE);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN          = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STORED_CHARS = 1'd1;

	localparam logic [7:0] MIN_LEN_RST          = 8'd3;
	localparam logic [7:0] MAX_STORED_CHARS_RST = 8'd99;

	localparam logic [31:0] MUL_EVEN = 32'd31;
	localparam logic [31:0] MUL_ODD  = 32'd37;
	localparam logic [31:0] MUL_ADD  = 32'd17;
	localparam logic [7:0]  CH_M     = 8'h6D;
	localparam logic [7:0]  CH_F     = 8'h66;
	localparam logic [7:0]  CASE_OFS = 8'h20;

	typedef struct packed {
		logic [31:0] hash;
		logic [7:0]  len;
	} token_t;

	typedef struct packed {
		logic [13:0] bucket;
		logic [7:0]  len;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ===== src/wth_front.sv =====
// Front end: classify bytes, fold word characters into the running hash, emit finished words.
module wth_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wth_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_wdata,
	input  logic                              push,
	input  logic [7:0]                        text_byte,
	input  logic                              end_of_text,
	input  wth_pkg::q_status_t                q_status,
	output logic                              tok_wr,
	output wth_pkg::token_t                   tok
);

	logic [7:0]  min_len_q;
	logic [7:0]  max_stored_q;
	logic [31:0] hash_q;
	logic [7:0]  len_q;

	logic        accept;
	logic        is_word;
	logic        is_upper;
	logic        store;
	logic        flush;
	logic [7:0]  c;
	logic [31:0] h_mul;
	logic [31:0] h_new;
	logic [31:0] fl_hash;
	logic [7:0]  fl_len;
	logic        emit;

	always_comb begin
		is_word  = text_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2D};
		is_upper = text_byte inside {[8'h41:8'h5A]};
		c        = is_upper ? text_byte + wth_pkg::CASE_OFS : text_byte;
		store    = is_word && (len_q < max_stored_q);
		h_mul    = (len_q[0] ? hash_q * wth_pkg::MUL_ODD : hash_q * wth_pkg::MUL_EVEN)
		           + {24'd0, c};
		if (c > wth_pkg::CH_M) begin
			h_new = h_mul ^ (h_mul << 5);
		end else if (c > wth_pkg::CH_F) begin
			h_new = h_mul ^ (h_mul >> 3);
		end else begin
			h_new = h_mul + ({24'd0, c} * wth_pkg::MUL_ADD);
		end
		flush   = !is_word || end_of_text;
		fl_hash = store ? h_new : hash_q;
		fl_len  = store ? len_q + 8'd1 : len_q;
		emit    = flush && (fl_len != 8'd0) && (fl_len >= min_len_q);
	end

	assign accept   = push && !q_status.full;
	assign tok_wr   = accept && emit;
	assign tok.hash = fl_hash;
	assign tok.len  = fl_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q    <= wth_pkg::MIN_LEN_RST;
			max_stored_q <= wth_pkg::MAX_STORED_CHARS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wth_pkg::REG_MIN_LEN:          min_len_q    <= cfg_wdata;
				wth_pkg::REG_MAX_STORED_CHARS: max_stored_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			len_q  <= '0;
		end else if (accept) begin
			if (flush) begin
				hash_q <= '0;
				len_q  <= '0;
			end else if (store) begin
				hash_q <= h_new;
				len_q  <= len_q + 8'd1;
			end
		end
	end

endmodule

// ===== src/wth_queue.sv =====
// Short token queue between the front end and the bucket reduction.
module wth_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  wth_pkg::token_t    wr_data,
	input  logic               rd,
	output wth_pkg::token_t    rd_data,
	output wth_pkg::q_status_t status
);

	wth_pkg::token_t                 mem_q [wth_pkg::QDEPTH];
	logic [wth_pkg::QPTR_W-1:0]      wptr_q;
	logic [wth_pkg::QPTR_W-1:0]      rptr_q;
	logic [wth_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == wth_pkg::QCNT_W'(wth_pkg::QDEPTH));
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/wth_back.sv =====
// Back end: reduce word hashes modulo the table size and queue the results.
module wth_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wth_pkg::q_status_t tq_status,
	input  wth_pkg::token_t    tq_data,
	output logic               tq_rd,
	input  logic               pop,
	output logic               empty,
	output logic [13:0]        bucket_index,
	output logic [7:0]         word_length
);

	logic                         en;
	logic                         s1_valid_q;
	logic [63:0]                  prod_s1;
	logic [31:0]                  hash_s1;
	logic [7:0]                   len_s1;
	logic                         s2_valid_q;
	logic [wth_pkg::RW-1:0]       rem_s2;
	logic [7:0]                   len_s2;
	logic [31:0]                  quot;
	logic [wth_pkg::RW-1:0]       rem_fix;

	wth_pkg::result_t             oq_q [wth_pkg::QDEPTH];
	logic [wth_pkg::QPTR_W-1:0]   owptr_q;
	logic [wth_pkg::QPTR_W-1:0]   orptr_q;
	logic [wth_pkg::QCNT_W-1:0]   ocnt_q;
	logic                         oq_full;
	logic                         oq_wr;
	logic                         oq_rd;
	wth_pkg::result_t             oq_in;

	assign oq_full = (ocnt_q == wth_pkg::QCNT_W'(wth_pkg::QDEPTH));
	assign en      = !(s2_valid_q && oq_full);
	assign tq_rd   = en && !tq_status.empty;
	assign quot    = 32'(prod_s1 >> wth_pkg::RECIP_SHIFT);
	assign rem_fix = (rem_s2 >= wth_pkg::TABLE_SIZE_R) ? rem_s2 - wth_pkg::TABLE_SIZE_R : rem_s2;
	assign oq_in.bucket = 14'(rem_fix);
	assign oq_in.len    = len_s2;
	assign oq_wr   = s2_valid_q && en;
	assign empty   = (ocnt_q == '0);
	assign oq_rd   = pop && !empty;
	assign bucket_index = oq_q[orptr_q].bucket;
	assign word_length  = oq_q[orptr_q].len;

	always_ff @(posedge clk) begin
		if (tq_rd) begin
			prod_s1 <= 64'(tq_data.hash) * 64'(wth_pkg::RECIP);
			hash_s1 <= tq_data.hash;
			len_s1  <= tq_data.len;
		end
		if (en && s1_valid_q) begin
			rem_s2 <= wth_pkg::RW'(hash_s1)
			          - (wth_pkg::RW'(quot) * wth_pkg::TABLE_SIZE_R);
			len_s2 <= len_s1;
		end
		if (oq_wr) begin
			oq_q[owptr_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			owptr_q    <= '0;
			orptr_q    <= '0;
			ocnt_q     <= '0;
		end else begin
			if (en) begin
				s1_valid_q <= !tq_status.empty;
				s2_valid_q <= s1_valid_q;
			end
			if (oq_wr) begin
				owptr_q <= owptr_q + 1'b1;
			end
			if (oq_rd) begin
				orptr_q <= orptr_q + 1'b1;
			end
			if (oq_wr && !oq_rd) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (oq_rd && !oq_wr) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= wth_pkg::QCNT_W'(wth_pkg::QDEPTH))
		else $error("result queue count overflow");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		oq_wr |-> (rem_fix < wth_pkg::TABLE_SIZE_R))
		else $error("bucket remainder out of range");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !en) |=> (s2_valid_q && $stable(rem_s2) && $stable(len_s2)))
		else $error("stalled stage two beat changed");

	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_full && !oq_rd) |=> $stable(ocnt_q))
		else $error("write into full result queue");
`endif

endmodule

// ===== src/word_tokenizer_hasher.sv =====
// Top level of the word tokenizer and hasher.
//
// Input channel: push/full. One text byte per beat, with end_of_text on the
// last byte of a text. A beat is taken at a clock edge with push high and
// full low; one byte can be taken every cycle.
// Result channel: empty/pop. While empty is low the oldest token is on
// bucket_index and word_length; pop with empty low takes it.
// A token leaves for the word that a delimiter byte or an end_of_text byte
// closes; it passes the token queue, stage one, stage two and the result
// queue. One hash step per byte gives one byte per cycle while full is low.
// Configuration: cfg_we with cfg_index 0 writes the shortest emitted word
// length, index 1 writes max_stored_chars; write only while no token is in
// flight.
// Reset clears the word state and all queues and loads a shortest emitted
// length of 3 and max_stored_chars 99.
// When the receiver stalls, tokens collect in a 4-deep result queue and a
// 4-deep token queue; full rises only once the token queue is full.
module word_tokenizer_hasher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wth_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    text_byte,
	input  logic                          end_of_text,
	output logic                          empty,
	input  logic                          pop,
	output logic [13:0]                   bucket_index,
	output logic [7:0]                    word_length
);

	wth_pkg::q_status_t tq_status;
	wth_pkg::token_t    tok;
	wth_pkg::token_t    tq_data;
	logic               tok_wr;
	logic               tq_rd;

	assign full = tq_status.full;

	wth_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_status    (tq_status),
		.tok_wr      (tok_wr),
		.tok         (tok)
	);

	wth_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tok_wr),
		.wr_data (tok),
		.rd      (tq_rd),
		.rd_data (tq_data),
		.status  (tq_status)
	);

	wth_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tq_status    (tq_status),
		.tq_data      (tq_data),
		.tq_rd        (tq_rd),
		.pop          (pop),
		.empty        (empty),
		.bucket_index (bucket_index),
		.word_length  (word_length)
	);

endmodule
